[design/pulse_width_rf_frame_transmitter_defines.svh]
// Assertion macros shared by the pulse frame transmitter modules.
`ifndef PULSE_WIDTH_RF_FRAME_TRANSMITTER_DEFINES_SVH
`define PULSE_WIDTH_RF_FRAME_TRANSMITTER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked property, switched off while reset is asserted.
`define PWFT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property that also holds during reset.
`define PWFT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PWFT_ASSERT(lbl, clk, rstn, prop, msg)
`define PWFT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/pwft_pkg.sv]
// Types and constants of the pulse frame transmitter.
package pwft_pkg;

  localparam int REG_W     = 16;
  localparam int RPT_W     = 4;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 3;

  // Request codes
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP         = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT      = 3'd7;

  typedef struct packed {
    logic              req_type;
    logic [BYTE_W-1:0] addr_byte;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
    logic message_done;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0] leader_high_ticks;
    logic [REG_W-1:0] leader_low_ticks;
    logic [REG_W-1:0] zero_high_ticks;
    logic [REG_W-1:0] zero_low_ticks;
    logic [REG_W-1:0] one_high_ticks;
    logic [REG_W-1:0] one_low_ticks;
    logic [REG_W-1:0] gap_ticks;
    logic [RPT_W-1:0] repeat_count;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    leader_high_ticks: 16'd360,
    leader_low_ticks:  16'd180,
    zero_high_ticks:   16'd22,
    zero_low_ticks:    16'd23,
    one_high_ticks:    16'd45,
    one_low_ticks:     16'd45,
    gap_ticks:         16'd220,
    repeat_count:      4'd6
  };

endpackage

[design/pwft_seq.sv]
// Segment sequencer: phase, tick count and bit position of the message in flight.
`include "pulse_width_rf_frame_transmitter_defines.svh"

module pwft_seq #(
  parameter int TICK_COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  pwft_pkg::in_item_t  item_i,
  input  pwft_pkg::cfg_t      cfg_i,
  output pwft_pkg::out_item_t res_o
);

  localparam int CntW = TICK_COUNT_BITS;
  localparam int PosW = 6;
  localparam int FrameBits = 4 * pwft_pkg::BYTE_W;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEAD_H, PH_LEAD_L, PH_BIT_H, PH_BIT_L, PH_STOP_H, PH_STOP_L, PH_GAP
  } phase_e;

  // Where the segment search starts after a segment ends or a message starts
  typedef enum logic [2:0] {
    EN_NONE, EN_LEAD_H, EN_LEAD_L, EN_FRAME, EN_BIT_L, EN_SEARCH, EN_STOP_L, EN_GAP
  } entry_e;

  function automatic logic [CntW-1:0] fit(input logic [pwft_pkg::REG_W-1:0] v);
    logic [CntW+pwft_pkg::REG_W-1:0] w;
    w = {{CntW{1'b0}}, v};
    return w[CntW-1:0];
  endfunction

  function automatic logic is_high(input phase_e p);
    return (p == PH_LEAD_H) || (p == PH_BIT_H) || (p == PH_STOP_H);
  endfunction

  phase_e                    phase_q, phase_d, phase_r;
  logic [CntW-1:0]           ticks_q, ticks_d, ticks_r;
  logic [PosW-1:0]           pos_q, pos_d, pos_r;
  logic [pwft_pkg::RPT_W-1:0] frames_q, frames_d, frames_r;
  logic [pwft_pkg::BYTE_W-1:0] addr_q, addr_d, data_q, data_d;

  logic is_start, start_ok, tick_run, seg_end;
  entry_e                    ent;
  logic [PosW-1:0]           ent_pos, srch_s;
  logic [pwft_pkg::RPT_W-1:0] ent_frames, frames_dec;

  logic [CntW-1:0] len_lh, len_ll, len_zh, len_zl, len_oh, len_ol, len_gp;
  logic lh0, ll0, zh0, zl0, oh0, ol0, gp0;
  logic [FrameBits-1:0] fbits, live;
  logic found_s, found_0;
  logic [4:0] idx_s, idx_0;
  logic b_ent, b_s, b_0;
  logic [CntW-1:0] bl_lo, s_hi, s_lo, z_hi, z_lo;
  logic from_frame, to_stop_h, to_stop_l, to_gap;

  // Segment lengths, cut to the counter width
  assign len_lh = fit(cfg_i.leader_high_ticks);
  assign len_ll = fit(cfg_i.leader_low_ticks);
  assign len_zh = fit(cfg_i.zero_high_ticks);
  assign len_zl = fit(cfg_i.zero_low_ticks);
  assign len_oh = fit(cfg_i.one_high_ticks);
  assign len_ol = fit(cfg_i.one_low_ticks);
  assign len_gp = fit(cfg_i.gap_ticks);
  assign lh0 = (len_lh == '0);
  assign ll0 = (len_ll == '0);
  assign zh0 = (len_zh == '0);
  assign zl0 = (len_zl == '0);
  assign oh0 = (len_oh == '0);
  assign ol0 = (len_ol == '0);
  assign gp0 = (len_gp == '0);

  // Item decode
  assign is_start = (item_i.req_type == pwft_pkg::REQ_START);
  assign start_ok = is_start && (phase_q == PH_IDLE);
  assign tick_run = !is_start && (phase_q != PH_IDLE);
  assign seg_end  = tick_run && (ticks_q == CntW'(1));

  // Bytes of the frame: a start item brings new ones
  assign addr_d = start_ok ? item_i.addr_byte : addr_q;
  assign data_d = start_ok ? item_i.data_byte : data_q;
  assign fbits  = {~data_d, data_d, ~addr_d, addr_d};

  // A bit whose high and low parts are both empty is passed over
  always_comb begin : bit_live
    for (int i = 0; i < FrameBits; i++) begin
      live[i] = fbits[i] ? !(oh0 && ol0) : !(zh0 && zl0);
    end
  end

  // Entry point of the segment search
  always_comb begin : entry_sel
    ent        = EN_NONE;
    ent_pos    = pos_q;
    ent_frames = frames_q;
    if (start_ok) begin
      ent        = EN_LEAD_H;
      ent_pos    = '0;
      ent_frames = cfg_i.repeat_count;
    end else if (seg_end) begin
      case (phase_q)
        PH_LEAD_H: ent = EN_LEAD_L;
        PH_LEAD_L: ent = EN_FRAME;
        PH_BIT_H:  ent = EN_BIT_L;
        PH_BIT_L: begin
          ent     = EN_SEARCH;
          ent_pos = pos_q + PosW'(1);
        end
        PH_STOP_H: ent = EN_STOP_L;
        PH_STOP_L: ent = EN_GAP;
        PH_GAP: begin
          ent        = EN_FRAME;
          ent_frames = frames_q - pwft_pkg::RPT_W'(1);
        end
        default:   ent = EN_NONE;
      endcase
    end
  end

  assign srch_s     = (ent == EN_BIT_L) ? ent_pos + PosW'(1) : ent_pos;
  assign frames_dec = ent_frames - pwft_pkg::RPT_W'(1);

  // First live bit at or after the search start, and from bit 0
  always_comb begin : find_first
    found_s = 1'b0;
    found_0 = 1'b0;
    idx_s   = '0;
    idx_0   = '0;
    for (int i = FrameBits - 1; i >= 0; i--) begin
      if (live[i] && (PosW'(i) >= srch_s)) begin
        found_s = 1'b1;
        idx_s   = 5'(i);
      end
      if (live[i]) begin
        found_0 = 1'b1;
        idx_0   = 5'(i);
      end
    end
  end

  assign b_ent = fbits[ent_pos[4:0]];
  assign b_s   = fbits[idx_s];
  assign b_0   = fbits[idx_0];
  assign bl_lo = b_ent ? len_ol : len_zl;
  assign s_hi  = b_s ? len_oh : len_zh;
  assign s_lo  = b_s ? len_ol : len_zl;
  assign z_hi  = b_0 ? len_oh : len_zh;
  assign z_lo  = b_0 ? len_ol : len_zl;

  assign from_frame = (ent inside {EN_LEAD_H, EN_LEAD_L, EN_FRAME});
  assign to_stop_h  = from_frame || (ent inside {EN_BIT_L, EN_SEARCH});
  assign to_stop_l  = to_stop_h || (ent == EN_STOP_L);
  assign to_gap     = to_stop_l || (ent == EN_GAP);

  // First segment of non-zero length from the entry point on
  always_comb begin : resolve
    phase_r  = PH_IDLE;
    ticks_r  = '0;
    pos_r    = ent_pos;
    frames_r = ent_frames;
    if ((ent == EN_LEAD_H) && !lh0) begin
      phase_r = PH_LEAD_H;
      ticks_r = len_lh;
    end else if (((ent == EN_LEAD_H) || (ent == EN_LEAD_L)) && !ll0) begin
      phase_r = PH_LEAD_L;
      ticks_r = len_ll;
    end else if ((ent == EN_BIT_L) && (bl_lo != '0)) begin
      phase_r = PH_BIT_L;
      ticks_r = bl_lo;
    end else if (((ent == EN_BIT_L) || (ent == EN_SEARCH)) && found_s) begin
      phase_r = (s_hi == '0) ? PH_BIT_L : PH_BIT_H;
      ticks_r = (s_hi == '0) ? s_lo : s_hi;
      pos_r   = {1'b0, idx_s};
    end else if (from_frame && (ent_frames == '0)) begin
      phase_r = PH_IDLE;
    end else if (from_frame && found_0) begin
      phase_r = (z_hi == '0) ? PH_BIT_L : PH_BIT_H;
      ticks_r = (z_hi == '0) ? z_lo : z_hi;
      pos_r   = {1'b0, idx_0};
    end else if (to_stop_h && !oh0) begin
      phase_r = PH_STOP_H;
      ticks_r = len_oh;
    end else if (to_stop_l && !ol0) begin
      phase_r = PH_STOP_L;
      ticks_r = len_ol;
    end else if (to_gap && !gp0) begin
      phase_r = PH_GAP;
      ticks_r = len_gp;
    end else if (to_gap && (frames_dec != '0) && found_0) begin
      // gap skipped, next frame begins
      phase_r  = (z_hi == '0) ? PH_BIT_L : PH_BIT_H;
      ticks_r  = (z_hi == '0) ? z_lo : z_hi;
      pos_r    = {1'b0, idx_0};
      frames_r = frames_dec;
    end
  end

  // Next state
  always_comb begin : next_state
    phase_d  = phase_q;
    ticks_d  = ticks_q;
    pos_d    = pos_q;
    frames_d = frames_q;
    if (start_ok || seg_end) begin
      phase_d  = phase_r;
      ticks_d  = ticks_r;
      pos_d    = pos_r;
      frames_d = frames_r;
    end else if (tick_run) begin
      ticks_d = ticks_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      ticks_q  <= '0;
      pos_q    <= '0;
      frames_q <= '0;
      addr_q   <= '0;
      data_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      ticks_q  <= ticks_d;
      pos_q    <= pos_d;
      frames_q <= frames_d;
      addr_q   <= addr_d;
      data_q   <= data_d;
    end
  end

  // Result of the item
  assign res_o.line_level   = is_start ? is_high(phase_d) : is_high(phase_q);
  assign res_o.busy_res     = (phase_d != PH_IDLE);
  assign res_o.accepted     = start_ok;
  assign res_o.message_done = seg_end && (phase_r == PH_IDLE);

  `PWFT_ASSERT(a_busy_has_count, clk_i, rst_ni, (phase_q != PH_IDLE) |-> (ticks_q != '0), "segment in progress with zero count")
  `PWFT_ASSERT_ALWAYS(a_bit_pos_range, clk_i, ((phase_q == PH_BIT_H) || (phase_q == PH_BIT_L)) |-> (pos_q < PosW'(FrameBits)), "bit position beyond frame")

endmodule

[design/pulse_width_rf_frame_transmitter.sv]
// Top level of the pulse frame transmitter: configuration registers and result register.
//
//  channel   direction  handshake                    payload
//  in        to block   in_valid_i / in_stall_o      in_item_i  (req_type, addr, data)
//  out       from block out_valid_o / out_stall_i    out_item_o (level, busy, accepted, done)
//  cfg       to block   cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// One item per clock; its result appears in the result register the cycle after.
// The sequencer resolves a whole segment change, skipped segments included, in that cycle.
// Reset clears the sequencer to idle and loads the register reset values.
// A stalled result holds; a new item is taken only while the result register is free
// or being read. Configuration writes are taken in every cycle.
`include "pulse_width_rf_frame_transmitter_defines.svh"

module pulse_width_rf_frame_transmitter #(
  parameter int TICK_COUNT_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  pwft_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pwft_pkg::out_item_t                out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pwft_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pwft_pkg::REG_W-1:0]        cfg_data_i
);

  pwft_pkg::cfg_t      cfg_q, cfg_d;
  pwft_pkg::out_item_t res;
  pwft_pkg::out_item_t out_item_q;
  logic                out_valid_q, out_valid_d;
  logic                step;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin : cfg_write
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        pwft_pkg::CFG_LEADER_HIGH: cfg_d.leader_high_ticks = cfg_data_i;
        pwft_pkg::CFG_LEADER_LOW:  cfg_d.leader_low_ticks  = cfg_data_i;
        pwft_pkg::CFG_ZERO_HIGH:   cfg_d.zero_high_ticks   = cfg_data_i;
        pwft_pkg::CFG_ZERO_LOW:    cfg_d.zero_low_ticks    = cfg_data_i;
        pwft_pkg::CFG_ONE_HIGH:    cfg_d.one_high_ticks    = cfg_data_i;
        pwft_pkg::CFG_ONE_LOW:     cfg_d.one_low_ticks     = cfg_data_i;
        pwft_pkg::CFG_GAP:         cfg_d.gap_ticks         = cfg_data_i;
        pwft_pkg::CFG_REPEAT:      cfg_d.repeat_count      = cfg_data_i[pwft_pkg::RPT_W-1:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= pwft_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Item handshake: take an item while the result register can move on
  assign in_stall_o = out_valid_q && out_stall_i;
  assign step       = in_valid_i && !in_stall_o;

  pwft_seq #(
    .TICK_COUNT_BITS(TICK_COUNT_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Result register
  assign out_valid_d = step || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `PWFT_ASSERT(a_item_gives_result, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> out_valid_o, "accepted item left no result")
  `PWFT_ASSERT(a_done_ends_message, clk_i, rst_ni, (out_valid_o && out_item_o.message_done) |-> (!out_item_o.busy_res && !out_item_o.accepted), "message end reported while busy")

endmodule

[test/tb.sv]
// Self-checking testbench of the pulse frame transmitter: a queue-fed driver, a predictor and a monitor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Predictor sizes: segment counter width and bits in one frame
  localparam int CNT_W       = 16;
  localparam int FRAME_BITS  = 32;
  // Cycles in which no item, result or configuration write moves before the run is abandoned
  localparam int STUCK_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 100;

  typedef enum logic [2:0] {
    S_IDLE, S_LEAD_H, S_LEAD_L, S_BIT_H, S_BIT_L, S_STOP_H, S_STOP_L, S_GAP
  } seg_e;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  pwft_pkg::in_item_t             in_item_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  pwft_pkg::out_item_t            out_item_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [pwft_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [pwft_pkg::REG_W-1:0]     cfg_data_i = '0;

  // Items waiting to be sent, and line results still owed by the block
  pwft_pkg::in_item_t  tx_q[$];
  pwft_pkg::out_item_t line_exp_q[$];

  // Predictor copy of the block's registers and sequencer
  pwft_pkg::cfg_t   m_cfg = pwft_pkg::CFG_RESET;
  seg_e             m_seg = S_IDLE;
  logic [CNT_W-1:0] m_left = '0;
  logic [5:0]       m_pos = '0;
  logic [3:0]       m_frames = '0;
  logic [7:0]       m_addr = '0;
  logic [7:0]       m_data = '0;

  int   fail_count = 0;
  int   n_results = 0;
  int   n_pushed = 0;
  int   stuck = 0;
  int   tx_rate = 0;
  int   rx_rate = 0;
  int   tx_hold = 0;
  int   rx_hold = 0;
  logic in_taken = 1'b0;

  pulse_width_rf_frame_transmitter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // Bit sent at a frame position: address, ~address, data, ~data, LSB first
  function automatic logic frame_bit(logic [7:0] a, logic [7:0] d, logic [5:0] pos);
    logic [7:0] src;
    src = (pos[4:0] < 5'd16) ? a : d;
    return src[pos[2:0]] ^ pos[3];
  endfunction

  function automatic logic [CNT_W-1:0] seg_len();
    logic [CNT_W-1:0] n;
    logic             b;
    b = frame_bit(m_addr, m_data, m_pos);
    case (m_seg)
      S_LEAD_H: n = m_cfg.leader_high_ticks;
      S_LEAD_L: n = m_cfg.leader_low_ticks;
      S_BIT_H:  n = b ? m_cfg.one_high_ticks : m_cfg.zero_high_ticks;
      S_BIT_L:  n = b ? m_cfg.one_low_ticks : m_cfg.zero_low_ticks;
      S_STOP_H: n = m_cfg.one_high_ticks;
      S_STOP_L: n = m_cfg.one_low_ticks;
      S_GAP:    n = m_cfg.gap_ticks;
      default:  n = '0;
    endcase
    return n;
  endfunction

  // Step to the following segment; its count is loaded separately
  function automatic void advance();
    case (m_seg)
      S_LEAD_H: m_seg = S_LEAD_L;
      S_LEAD_L: begin
        if (m_frames != 0) begin
          m_pos = '0;
          m_seg = S_BIT_H;
        end else begin
          m_seg = S_IDLE;
        end
      end
      S_BIT_H: m_seg = S_BIT_L;
      S_BIT_L: begin
        m_pos = m_pos + 6'd1;
        m_seg = (m_pos < FRAME_BITS) ? S_BIT_H : S_STOP_H;
      end
      S_STOP_H: m_seg = S_STOP_L;
      S_STOP_L: m_seg = S_GAP;
      S_GAP: begin
        m_frames = m_frames - 4'd1;
        if (m_frames != 0) begin
          m_pos = '0;
          m_seg = S_BIT_H;
        end else begin
          m_seg = S_IDLE;
        end
      end
      default: m_seg = S_IDLE;
    endcase
  endfunction

  // Load the current segment's count, passing over empty segments
  function automatic void load_segment();
    while (m_seg != S_IDLE) begin
      m_left = seg_len();
      if (m_left != 0) return;
      advance();
    end
    m_left = '0;
  endfunction

  function automatic logic line_high();
    return (m_seg == S_LEAD_H) || (m_seg == S_BIT_H) || (m_seg == S_STOP_H);
  endfunction

  function automatic pwft_pkg::out_item_t predict_line(pwft_pkg::in_item_t it);
    pwft_pkg::out_item_t r;
    r = '0;
    if (it.req_type == pwft_pkg::REQ_START) begin
      if (m_seg == S_IDLE) begin
        m_addr   = it.addr_byte;
        m_data   = it.data_byte;
        m_frames = m_cfg.repeat_count;
        m_pos    = '0;
        m_seg    = S_LEAD_H;
        load_segment();
        r.accepted = 1'b1;
      end
      r.line_level = line_high();
    end else if (m_seg != S_IDLE) begin
      r.line_level = line_high();
      m_left = m_left - 1'b1;
      if (m_left == 0) begin
        advance();
        load_segment();
        r.message_done = (m_seg == S_IDLE);
      end
    end
    r.busy_res = (m_seg != S_IDLE);
    return r;
  endfunction

  function automatic void apply_reg(logic [pwft_pkg::CFG_IDX_W-1:0] idx,
                                    logic [pwft_pkg::REG_W-1:0] v);
    case (idx)
      pwft_pkg::CFG_LEADER_HIGH: m_cfg.leader_high_ticks = v;
      pwft_pkg::CFG_LEADER_LOW:  m_cfg.leader_low_ticks  = v;
      pwft_pkg::CFG_ZERO_HIGH:   m_cfg.zero_high_ticks   = v;
      pwft_pkg::CFG_ZERO_LOW:    m_cfg.zero_low_ticks    = v;
      pwft_pkg::CFG_ONE_HIGH:    m_cfg.one_high_ticks    = v;
      pwft_pkg::CFG_ONE_LOW:     m_cfg.one_low_ticks     = v;
      pwft_pkg::CFG_GAP:         m_cfg.gap_ticks         = v;
      pwft_pkg::CFG_REPEAT:      m_cfg.repeat_count      = v[pwft_pkg::RPT_W-1:0];
      default: ;
    endcase
  endfunction

  // Ticks a whole message lasts under the present registers
  function automatic int msg_ticks(logic [7:0] a, logic [7:0] d);
    int frame;
    int b;
    frame = int'(m_cfg.one_high_ticks) + int'(m_cfg.one_low_ticks) + int'(m_cfg.gap_ticks);
    for (b = 0; b < FRAME_BITS; b++) begin
      if (frame_bit(a, d, b[5:0]))
        frame += int'(m_cfg.one_high_ticks) + int'(m_cfg.one_low_ticks);
      else
        frame += int'(m_cfg.zero_high_ticks) + int'(m_cfg.zero_low_ticks);
    end
    return int'(m_cfg.leader_high_ticks) + int'(m_cfg.leader_low_ticks)
           + int'(m_cfg.repeat_count) * frame;
  endfunction

  // ---------------------------------------------------------------- driver and monitor

  // Item side: hold a stalled item, otherwise idle in bursts or send the next one
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (tx_rate != 0 && tx_hold != 0) begin
        in_valid_i <= 1'b0;
        tx_hold    <= tx_hold - 1;
      end else if (tx_rate != 0 && $urandom_range(0, 15) < tx_rate) begin
        in_valid_i <= 1'b0;
        tx_hold    <= $urandom_range(0, 14);
      end else if (tx_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_item_i  <= tx_q[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side: stall in bursts
  always @(negedge clk_i) begin
    if (rx_rate == 0) begin
      out_stall_i <= 1'b0;
    end else if (rx_hold != 0) begin
      out_stall_i <= 1'b1;
      rx_hold     <= rx_hold - 1;
    end else if ($urandom_range(0, 15) < rx_rate) begin
      out_stall_i <= 1'b1;
      rx_hold     <= $urandom_range(0, 14);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  // Accepted items feed the predictor; accepted results are checked in order
  always @(posedge clk_i) begin : p_check
    logic                in_fire;
    logic                out_fire;
    pwft_pkg::out_item_t want;
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    if (out_fire) begin
      n_results++;
      if (line_exp_q.size() == 0) begin
        note_fail($sformatf("result %0d arrived with nothing expected", n_results));
      end else begin
        want = line_exp_q.pop_front();
        if (out_item_o.line_level !== want.line_level || out_item_o.busy_res !== want.busy_res
            || out_item_o.accepted !== want.accepted
            || out_item_o.message_done !== want.message_done)
          note_fail($sformatf(
            "result %0d exp/got: line %b/%b busy %b/%b accepted %b/%b done %b/%b",
            n_results, want.line_level, out_item_o.line_level, want.busy_res,
            out_item_o.busy_res, want.accepted, out_item_o.accepted,
            want.message_done, out_item_o.message_done));
      end
    end
    if (in_fire) begin
      line_exp_q.push_back(predict_line(in_item_i));
      void'(tx_q.pop_front());
    end
    in_taken <= in_fire;
  end

  // Watchdog on cycles in which nothing moves
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_item(logic req, logic [7:0] a, logic [7:0] d);
    pwft_pkg::in_item_t it;
    it.req_type  = req;
    it.addr_byte = a;
    it.data_byte = d;
    tx_q.push_back(it);
    n_pushed++;
  endtask

  task automatic push_ticks(int n);
    for (int i = 0; i < n; i++)
      push_item(pwft_pkg::REQ_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Start plus the exact ticks of the message, adjusted by slack; optionally a stray start
  task automatic send_message(logic [7:0] a, logic [7:0] d, int slack, logic stray);
    int n;
    int poke;
    n    = msg_ticks(a, d) + slack;
    poke = (stray && n > 0) ? int'($urandom_range(0, n - 1)) : -1;
    push_item(pwft_pkg::REQ_START, a, d);
    for (int i = 0; i < n; i++) begin
      if (i == poke)
        push_item(pwft_pkg::REQ_START, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      push_ticks(1);
    end
  endtask

  task automatic wait_sent();
    while (tx_q.size() != 0) @(posedge clk_i);
  endtask

  // Sender pauses until every owed result is back, then the block settles
  task automatic settle_out();
    wait_sent();
    while (line_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Tick in small batches until the predictor says the message is over
  task automatic run_to_idle();
    do begin
      push_ticks(32);
      wait_sent();
    end while (m_seg != S_IDLE);
  endtask

  task automatic write_reg(logic [pwft_pkg::CFG_IDX_W-1:0] idx,
                           logic [pwft_pkg::REG_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_cfg(pwft_pkg::cfg_t c);
    logic [pwft_pkg::REG_W-pwft_pkg::RPT_W-1:0] pad;
    pad = (pwft_pkg::REG_W - pwft_pkg::RPT_W)'(
            $urandom_range(0, (1 << (pwft_pkg::REG_W - pwft_pkg::RPT_W)) - 1));
    write_reg(pwft_pkg::CFG_LEADER_HIGH, c.leader_high_ticks);
    write_reg(pwft_pkg::CFG_LEADER_LOW,  c.leader_low_ticks);
    write_reg(pwft_pkg::CFG_ZERO_HIGH,   c.zero_high_ticks);
    write_reg(pwft_pkg::CFG_ZERO_LOW,    c.zero_low_ticks);
    write_reg(pwft_pkg::CFG_ONE_HIGH,    c.one_high_ticks);
    write_reg(pwft_pkg::CFG_ONE_LOW,     c.one_low_ticks);
    write_reg(pwft_pkg::CFG_GAP,         c.gap_ticks);
    write_reg(pwft_pkg::CFG_REPEAT,      {pad, c.repeat_count});
  endtask

  // Short segments, now and then empty ones
  function automatic logic [pwft_pkg::REG_W-1:0] rand_len();
    return ($urandom_range(0, 7) == 0) ? '0 : pwft_pkg::REG_W'($urandom_range(1, 2));
  endfunction

  function automatic pwft_pkg::cfg_t random_cfg();
    pwft_pkg::cfg_t c;
    c.leader_high_ticks = rand_len();
    c.leader_low_ticks  = rand_len();
    c.zero_high_ticks   = rand_len();
    c.zero_low_ticks    = rand_len();
    c.one_high_ticks    = rand_len();
    c.one_low_ticks     = rand_len();
    c.gap_ticks         = rand_len();
    c.repeat_count = ($urandom_range(0, 7) == 0) ? pwft_pkg::RPT_W'($urandom_range(0, 3))
                                                 : pwft_pkg::RPT_W'(1);
    return c;
  endfunction

  task automatic set_pace();
    tx_rate = $urandom_range(0, 3);
    rx_rate = $urandom_range(0, 3);
  endtask

  initial begin : p_stim
    pwft_pkg::cfg_t c;
    int             base;
    int             k;
    int             slack;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    set_pace();

    // Reset timings: idle tick, a start, a start while busy, then a few leader ticks
    push_ticks(1);
    push_item(pwft_pkg::REQ_START, 8'hA5, 8'h3C);
    push_item(pwft_pkg::REQ_START, 8'hFF, 8'h00);
    push_ticks(5);
    settle_out();

    // Rewrite every register mid-message; the leader in progress keeps its count
    c = '{leader_high_ticks: 16'd3, leader_low_ticks: 16'd2, zero_high_ticks: 16'd1,
          zero_low_ticks: 16'd1, one_high_ticks: 16'd2, one_low_ticks: 16'd1,
          gap_ticks: 16'd0, repeat_count: 4'd1};
    write_cfg(c);
    run_to_idle();
    settle_out();

    // Empty segments scattered over the frame, zero gap, back-to-back messages
    c = '{leader_high_ticks: 16'd0, leader_low_ticks: 16'd2, zero_high_ticks: 16'd1,
          zero_low_ticks: 16'd0, one_high_ticks: 16'd0, one_low_ticks: 16'd1,
          gap_ticks: 16'd0, repeat_count: 4'd2};
    write_cfg(c);
    send_message(8'h00, 8'hFF, 0, 1'b0);
    send_message(8'hFF, 8'h00, 1, 1'b0);
    settle_out();

    // No frames: the leader alone, then a message with nothing in it at all
    c = '{leader_high_ticks: 16'd2, leader_low_ticks: 16'd3, zero_high_ticks: 16'd1,
          zero_low_ticks: 16'd1, one_high_ticks: 16'd1, one_low_ticks: 16'd1,
          gap_ticks: 16'd1, repeat_count: 4'd0};
    write_cfg(c);
    send_message(8'h5A, 8'hC3, 1, 1'b0);
    settle_out();
    c = '0;
    write_cfg(c);
    send_message(8'h81, 8'h7E, 1, 1'b0);
    settle_out();

    // Every timing empty but several frames: the start ends the message at once
    c.repeat_count = 4'd3;
    write_cfg(c);
    send_message(8'h96, 8'h69, 1, 1'b0);
    settle_out();

    // The most frames, each of them nothing but its gap
    c = '{leader_high_ticks: 16'd1, leader_low_ticks: 16'd1, zero_high_ticks: 16'd0,
          zero_low_ticks: 16'd0, one_high_ticks: 16'd0, one_low_ticks: 16'd0,
          gap_ticks: 16'd1, repeat_count: 4'd15};
    write_cfg(c);
    send_message(8'hFF, 8'hFF, 0, 1'b1);
    settle_out();

    // Random phases: mostly whole messages, with stray items and cut or padded tick runs
    base = n_pushed;
    while (n_pushed - base < RANDOM_ITEMS) begin
      set_pace();
      write_cfg(random_cfg());
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 4))
            push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        k = $urandom_range(0, 7);
        slack = (k == 0) ? -2 : (k == 1) ? int'($urandom_range(1, 5)) : 0;
        send_message(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), slack,
                     $urandom_range(0, 2) == 0);
      end
      settle_out();
    end

    // Closing stretch at full rate on both sides
    tx_rate = 0;
    rx_rate = 0;
    write_cfg(random_cfg());
    send_message(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, 1'b0);
    wait_sent();
    while (line_exp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
